// File: hdl/led_dimming_pattern_generator_assert.svh
// assertion macros used by the checker file
`ifndef LED_DIMMING_PATTERN_GENERATOR_ASSERT_SVH
`define LED_DIMMING_PATTERN_GENERATOR_ASSERT_SVH

// same-cycle implication
`define LDPG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LDPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/ldpg_pkg.sv
package ldpg_pkg;

   localparam int LEVELS    = 32;
   localparam int PHASES    = 31;
   localparam int ROWS      = 8;
   localparam int ROW_WIDTH = 12;
   localparam int CTRL_BITS = 12;

   // field widths
   localparam int CMD_W     = 2;
   localparam int ROW_IDX_W = 3;
   localparam int OFF_W     = 4;
   localparam int CNT_W     = 4;
   localparam int BRIGHT_W  = 48;
   localparam int PHASE_W   = 5;
   localparam int MODE_W    = 2;
   localparam int BYTE_W    = 8;
   localparam int LEVEL_W   = $clog2(LEVELS);
   localparam int SHIFT_W   = CTRL_BITS + (2 ** OFF_W) - 1;

   // store address is {page, phase, row}
   localparam int ADDR_W    = 1 + PHASE_W + ROW_IDX_W;
   localparam int RAM_DEPTH = 2 ** ADDR_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_UPDATE = 2'd0,
      CMD_SWAP   = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_NORMAL    = 2'd0,
      MODE_LAMP_TEST = 2'd1,
      MODE_ALL_TEST  = 2'd2,
      MODE_POWERLESS = 2'd3
   } mode_type;

   typedef struct packed {
      logic clear_en;
      logic capture;
      logic update_en;
      logic read_en;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic update_done;
      logic rsp_free;
   } dp_stat_type;

   // on/off per level, leftmost digit is phase 0
   localparam logic [PHASES-1:0] DIM_TABLE [LEVELS] = '{
      31'b0000000000_0000000000_0000000000_0,
      31'b1000000000_0000000000_0000000000_0,
      31'b1000000000_0000000000_0000000000_0,
      31'b1000000000_0000000000_0000000000_0,
      31'b1000000000_0000000000_0000000000_0,
      31'b1000000000_0000001000_0000000000_0,
      31'b1000000000_0000001000_0000000000_0,
      31'b1000000000_0000001000_0000000000_0,
      31'b1000000000_0000001000_0000000000_0,
      31'b1000000000_0000001000_0000000000_0,
      31'b1000000000_1000000000_0100000000_0,
      31'b1000000000_1000000000_0100000000_0,
      31'b1000000000_1000000000_0100000000_0,
      31'b1000000010_0000001000_0001000000_0,
      31'b1000000010_0000001000_0001000000_0,
      31'b1000001000_0010000001_0000010000_0,
      31'b1000001000_0010000001_0000010000_0,
      31'b1000010000_1000001000_0100001000_0,
      31'b1000100001_0001000010_0010000100_0,
      31'b1000100001_0001000010_0010000100_0,
      31'b1000100010_0010001001_0001000100_0,
      31'b1001000100_1000100100_0100100010_0,
      31'b1001001001_0010001001_0010010010_0,
      31'b1001001010_0100100100_1001010010_0,
      31'b1010010100_1010100101_0100101001_0,
      31'b1010100101_0101001010_1010100101_0,
      31'b1010101010_1010101101_0101010101_0,
      31'b1011010101_1010101101_0110101011_0,
      31'b1011011011_0110101101_1011011011_0,
      31'b1101101110_1101101110_1101110110_1,
      31'b1110111101_1110111101_1110111101_1,
      31'b1111101111_1111101111_1111110111_1
   };

endpackage

// File: hdl/ldpg_req_if.sv
interface ldpg_req_if import ldpg_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     command;
   logic [ROW_IDX_W-1:0] row;
   logic [OFF_W-1:0]     lsb_pos;
   logic [CNT_W-1:0]     bit_count;
   logic [BRIGHT_W-1:0]  brightness_low;
   logic [BRIGHT_W-1:0]  brightness_high;
   logic [PHASE_W-1:0]   read_phase;

   modport source (
      output valid, command, row, lsb_pos, bit_count,
             brightness_low, brightness_high, read_phase,
      input  ready
   );

   modport sink (
      input  valid, command, row, lsb_pos, bit_count,
             brightness_low, brightness_high, read_phase,
      output ready
   );
endinterface

// File: hdl/ldpg_rsp_if.sv
interface ldpg_rsp_if import ldpg_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ROW_WIDTH-1:0] row_bits;
   logic                 read_page;

   modport source (
      output valid, row_bits, read_page,
      input  ready
   );

   modport sink (
      input  valid, row_bits, read_page,
      output ready
   );
endinterface

// File: hdl/led_dimming_pattern_generator.sv
// channel    direction  handshake          payload
// req_port   in         valid / ready      command, row, lsb_pos, bit_count,
//                                          brightness_low, brightness_high, read_phase
// rsp_port   out        valid / ready      row_bits, read_page
// csr_*      in         csr_write_enable   csr_write_data (panel mode)
//
// update word: a read-modify-write sweep over the 31 phases through the one-write
//   store, then the result hand-off
// read word: a store read of the other page, then the result; swap or unused command: straight to the result
// after reset a clearing pass runs over all 512 store words, ready stays low
// one word in flight; the result register lets the next word in while a
//   result waits, and a stalled result holds the sequencer in its last step
module led_dimming_pattern_generator import ldpg_pkg::*; (
   input logic              clock,
   input logic              reset,
   ldpg_req_if.sink         req_port,
   ldpg_rsp_if.source       rsp_port,
   input logic              csr_write_enable,
   input logic [MODE_W-1:0] csr_write_data
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // sequencer: clearing pass, accept, phase sweep, result hand-off
   ldpg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_port.valid),
      .req_command (req_port.command),
      .req_ready   (req_port.ready),
      .dp_stat     (dp_stat),
      .dp_cmd      (dp_cmd)
   );

   // datapath: level lookup, row merge, paged store, result register
   ldpg_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .dp_cmd              (dp_cmd),
      .dp_stat             (dp_stat),
      .req_command         (req_port.command),
      .req_row             (req_port.row),
      .req_lsb_pos         (req_port.lsb_pos),
      .req_bit_count       (req_port.bit_count),
      .req_brightness_low  (req_port.brightness_low),
      .req_brightness_high (req_port.brightness_high),
      .req_read_phase      (req_port.read_phase),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_valid           (rsp_port.valid),
      .rsp_ready           (rsp_port.ready),
      .rsp_row_bits        (rsp_port.row_bits),
      .rsp_read_page       (rsp_port.read_page)
   );

endmodule

// File: hdl/ldpg_ram.sv
module ldpg_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 512,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/ldpg_ctrl.sv
module ldpg_ctrl import ldpg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [CMD_W-1:0] req_command,
   output logic             req_ready,
   input  dp_stat_type      dp_stat,
   output dp_cmd_type       dp_cmd
);

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_UPDATE = 5'b00100,
      ST_READ   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      dp_cmd    = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            dp_cmd.clear_en = 1'b1;
            if (dp_stat.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_cmd.capture = 1'b1;
               if (req_command == CMD_UPDATE) begin
                  state_in = ST_UPDATE;
               end else if (req_command == CMD_READ) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_UPDATE: begin
            dp_cmd.update_en = 1'b1;
            if (dp_stat.update_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_READ: begin
            dp_cmd.read_en = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            if (dp_stat.rsp_free) begin
               dp_cmd.load_rsp = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

// File: hdl/ldpg_dpath.sv
module ldpg_dpath import ldpg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           dp_cmd,
   output dp_stat_type          dp_stat,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [ROW_IDX_W-1:0] req_row,
   input  logic [OFF_W-1:0]     req_lsb_pos,
   input  logic [CNT_W-1:0]     req_bit_count,
   input  logic [BRIGHT_W-1:0]  req_brightness_low,
   input  logic [BRIGHT_W-1:0]  req_brightness_high,
   input  logic [PHASE_W-1:0]   req_read_phase,
   input  logic                 csr_write_enable,
   input  logic [MODE_W-1:0]    csr_write_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ROW_WIDTH-1:0] rsp_row_bits,
   output logic                 rsp_read_page
);

   // captured word
   logic [CMD_W-1:0]     cmd_ff;
   logic [ROW_IDX_W-1:0] row_ff;
   logic [OFF_W-1:0]     off_ff;
   logic [CTRL_BITS-1:0] low_mask_ff;
   logic [ROW_WIDTH-1:0] row_mask_ff;
   logic [LEVEL_W-1:0]   lvl_ff [CTRL_BITS];
   logic [PHASE_W-1:0]   rphase_ff;

   // sequencing and page state
   logic [PHASE_W-1:0]   ph_ff;
   logic [ADDR_W-1:0]    clr_ff;
   logic                 wpage_ff;
   mode_type             mode_ff;

   // result register
   logic                 rsp_valid_ff;
   logic [ROW_WIDTH-1:0] row_bits_ff;
   logic                 read_page_ff;

   logic [2*BRIGHT_W-1:0] bright_all;
   logic [CNT_W-1:0]      cnt_clamp;
   logic [CTRL_BITS-1:0]  low_mask_in;
   logic [ROW_WIDTH-1:0]  row_mask_in;
   logic [PHASE_W-1:0]    wr_ph;
   logic [PHASE_W-1:0]    tbl_idx;
   logic [CTRL_BITS-1:0]  pat_val;
   logic [ROW_WIDTH-1:0]  pat_bits;
   logic [ROW_WIDTH-1:0]  merged;
   logic                  read_ok;
   logic [ROW_WIDTH-1:0]  row_bits_in;

   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [ROW_WIDTH-1:0]  ram_wr_data;
   logic                  ram_rd_en;
   logic [ADDR_W-1:0]     ram_rd_addr;
   logic [ROW_WIDTH-1:0]  ram_rd_data;

   // control mask and levels of the incoming word
   assign bright_all  = {req_brightness_high, req_brightness_low};
   assign cnt_clamp   = (req_bit_count > CNT_W'(CTRL_BITS)) ? CNT_W'(CTRL_BITS)
                                                            : req_bit_count;
   assign low_mask_in = CTRL_BITS'(((CTRL_BITS+1)'(1) << cnt_clamp) - (CTRL_BITS+1)'(1));
   assign row_mask_in = ROW_WIDTH'(SHIFT_W'(low_mask_in) << req_lsb_pos);

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         cmd_ff      <= req_command;
         row_ff      <= req_row;
         off_ff      <= req_lsb_pos;
         low_mask_ff <= low_mask_in;
         row_mask_ff <= row_mask_in;
         rphase_ff   <= req_read_phase;
         for (int i = 0; i < CTRL_BITS; i++) begin
            lvl_ff[i] <= LEVEL_W'(bright_all[i*BYTE_W +: BYTE_W] >> (BYTE_W - LEVEL_W));
         end
      end
   end

   // phase counter: read phase ph_ff, write back phase ph_ff - 1
   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         ph_ff <= '0;
      end else if (dp_cmd.update_en) begin
         ph_ff <= ph_ff + PHASE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (dp_cmd.clear_en) begin
         clr_ff <= clr_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
      end else if (csr_write_enable) begin
         mode_ff <= mode_type'(csr_write_data);
      end
   end

   // pattern bits of the phase being written back
   assign wr_ph   = ph_ff - PHASE_W'(1);
   assign tbl_idx = PHASE_W'(PHASES - 1) - wr_ph;

   always_comb begin
      for (int i = 0; i < CTRL_BITS; i++) begin
         pat_val[i] = DIM_TABLE[lvl_ff[i]][tbl_idx] & low_mask_ff[i];
      end
   end

   assign pat_bits = ROW_WIDTH'(SHIFT_W'(pat_val) << off_ff);

   always_comb begin
      unique case (mode_ff) inside
         MODE_NORMAL:                   merged = (ram_rd_data & ~row_mask_ff) | pat_bits;
         MODE_LAMP_TEST, MODE_ALL_TEST: merged = ram_rd_data | row_mask_ff;
         default:                       merged = '0;
      endcase
   end

   // store ports: clearing pass or update write, update or row read
   assign ram_wr_en   = dp_cmd.clear_en || (dp_cmd.update_en && (ph_ff != '0));
   assign ram_wr_addr = dp_cmd.clear_en ? clr_ff : {wpage_ff, wr_ph, row_ff};
   assign ram_wr_data = dp_cmd.clear_en ? '0 : merged;
   assign ram_rd_en   = dp_cmd.read_en ||
                        (dp_cmd.update_en && (ph_ff < PHASE_W'(PHASES)));
   assign ram_rd_addr = dp_cmd.read_en ? {~wpage_ff, rphase_ff, row_ff}
                                       : {wpage_ff, ph_ff, row_ff};

   ldpg_ram #(
      .WIDTH (ROW_WIDTH),
      .DEPTH (RAM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // result word
   assign read_ok     = (cmd_ff == CMD_READ) && (int'(row_ff) < ROWS) &&
                        (rphase_ff < PHASE_W'(PHASES));
   assign row_bits_in = read_ok ? ram_rd_data : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wpage_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (dp_cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
            if (cmd_ff == CMD_SWAP) begin
               wpage_ff <= ~wpage_ff;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load_rsp) begin
         row_bits_ff  <= row_bits_in;
         read_page_ff <= (cmd_ff == CMD_SWAP) ? wpage_ff : ~wpage_ff;
      end
   end

   assign dp_stat.clear_done  = (clr_ff == ADDR_W'(RAM_DEPTH - 1));
   assign dp_stat.update_done = (ph_ff == PHASE_W'(PHASES));
   assign dp_stat.rsp_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_bits  = row_bits_ff;
   assign rsp_read_page = read_page_ff;

endmodule

// File: hdl/ldpg_checker.sv
`include "led_dimming_pattern_generator_assert.svh"

module ldpg_checker import ldpg_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [ROW_WIDTH-1:0] rsp_row_bits,
   input logic                 rsp_read_page
);

   // a stalled result keeps its word
   `LDPG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_row_bits) && $stable(rsp_read_page), "stalled result changed")

   // one word at a time: busy right after an accept
   `LDPG_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "word accepted while busy")

   // the clearing pass follows reset with nothing shown
   `LDPG_ASSERT_NOW(a_clear_after_reset, clock, reset, $fell(reset), !req_ready && !rsp_valid, "ready or result right after reset")

endmodule

bind led_dimming_pattern_generator ldpg_checker u_ldpg_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_port.valid),
   .req_ready     (req_port.ready),
   .rsp_valid     (rsp_port.valid),
   .rsp_ready     (rsp_port.ready),
   .rsp_row_bits  (rsp_port.row_bits),
   .rsp_read_page (rsp_port.read_page)
);
